// ===== sv/sdn_pkg.sv =====
// sdn_pkg: shared constants and control struct for the direction normalizer.
// No dependencies.
`timescale 1ns / 1ps

package sdn_pkg;

  localparam int unsigned COORD_WIDTH = 32;
  localparam int unsigned THR_W       = 31;
  localparam int unsigned RES_BITS    = 17;  // result magnitude bits, 0..65536
  localparam int unsigned OUT_W       = 18;  // signed Q1.16
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(66);
  localparam logic [RES_BITS-1:0] RES_ONE = RES_BITS'(65536);

  typedef struct packed {
    logic valid;
    logic is_null;
    logic is_zero;
  } ctrl_t;

endpackage

// ===== sv/sdn_prep.sv =====
// sdn_prep: three-stage front end: magnitudes and null test, squares, sum.
// Depends on sdn_pkg.
`timescale 1ns / 1ps

module sdn_prep #(
  parameter int unsigned CW = sdn_pkg::COORD_WIDTH,
  parameter int unsigned SW = 2 * CW + 2,
  parameter int unsigned TW = 2 * CW + 31
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [sdn_pkg::THR_W-1:0] thr_i,
  input  logic [2:0][CW-1:0]       vec_i,
  output sdn_pkg::ctrl_t           ctrl_o,
  output logic [2:0]               neg_o,
  output logic [SW-1:0]            sum_o,
  output logic [2:0][TW-1:0]       tgt_o
);

  localparam int unsigned CMPW = CW + sdn_pkg::THR_W;

  sdn_pkg::ctrl_t        c1_q, c2_q, c3_q;
  logic [2:0]            n1_q, n2_q, n3_q;
  logic [2:0][CW-1:0]    mag_q;
  logic [2:0][2*CW-1:0]  sq_q;
  logic [SW-1:0]         sum_q;
  logic [2:0][TW-1:0]    tgt_q;

  logic [2:0][CW-1:0] mag_d;
  logic [2:0]         below;
  logic [SW-1:0]      sum_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_d[i] = vec_i[i][CW-1] ? (~vec_i[i] + CW'(1)) : vec_i[i];
      below[i] = (CMPW'(mag_d[i]) < CMPW'(thr_i));
    end
    sum_d = SW'(sq_q[0]) + SW'(sq_q[1]) + SW'(sq_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0;
      c2_q <= '0;
      c3_q <= '0;
    end else if (en_i) begin
      c1_q <= '{valid: valid_i, is_null: &below, is_zero: 1'b0};
      c2_q <= c1_q;
      c3_q <= '{valid: c2_q.valid, is_null: c2_q.is_null, is_zero: (sum_d == '0)};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n1_q <= {vec_i[2][CW-1], vec_i[1][CW-1], vec_i[0][CW-1]};
      n2_q <= n1_q;
      n3_q <= n2_q;
      mag_q <= mag_d;
      for (int i = 0; i < 3; i++) begin
        sq_q[i]  <= mag_q[i] * mag_q[i];
        tgt_q[i] <= TW'(sq_q[i]) << 32;
      end
      sum_q <= sum_d;
    end
  end

  assign ctrl_o = c3_q;
  assign neg_o  = n3_q;
  assign sum_o  = sum_q;
  assign tgt_o  = tgt_q;

endmodule

// ===== sv/sdn_cell.sv =====
// sdn_cell: one result bit for all three lanes, restoring square-compare step.
// Depends on sdn_pkg.
`timescale 1ns / 1ps

module sdn_cell #(
  parameter int unsigned CW  = sdn_pkg::COORD_WIDTH,
  parameter int unsigned BIT = 0,
  parameter int unsigned SW  = 2 * CW + 2,
  parameter int unsigned TW  = 2 * CW + 31,
  parameter int unsigned PW  = SW + sdn_pkg::RES_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  sdn_pkg::ctrl_t                     ctrl_i,
  input  logic [2:0]                         neg_i,
  input  logic [SW-1:0]                      sum_i,
  input  logic [2:0][TW-1:0]                 rem_i,
  input  logic [2:0][PW-1:0]                 p_i,
  input  logic [2:0][sdn_pkg::RES_BITS-1:0]  r_i,
  output sdn_pkg::ctrl_t                     ctrl_o,
  output logic [2:0]                         neg_o,
  output logic [SW-1:0]                      sum_o,
  output logic [2:0][TW-1:0]                 rem_o,
  output logic [2:0][PW-1:0]                 p_o,
  output logic [2:0][sdn_pkg::RES_BITS-1:0]  r_o
);

  localparam int unsigned DW  = 2 * CW + 37;
  localparam int unsigned TOP = sdn_pkg::RES_BITS - 1;

  sdn_pkg::ctrl_t                     ctrl_q;
  logic [2:0]                         neg_q;
  logic [SW-1:0]                      sum_q;
  logic [2:0][TW-1:0]                 rem_q;
  logic [2:0][PW-1:0]                 p_q;
  logic [2:0][sdn_pkg::RES_BITS-1:0]  r_q;

  logic [2:0][DW-1:0] delta;
  logic [2:0]         take;

  // (r + 2^b)^2 S - r^2 S = 2^(b+1) rS + 2^(2b) S, with P = rS kept alongside
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      delta[i] = (DW'(p_i[i]) << (BIT + 1)) + (DW'(sum_i) << (2 * BIT));
      take[i]  = (delta[i] <= DW'(rem_i[i])) && !((BIT < TOP) && r_i[i][TOP]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q <= neg_i;
      sum_q <= sum_i;
      for (int i = 0; i < 3; i++) begin
        rem_q[i] <= take[i] ? (rem_i[i] - delta[i][TW-1:0]) : rem_i[i];
        p_q[i]   <= take[i] ? (p_i[i] + (PW'(sum_i) << BIT)) : p_i[i];
        r_q[i]   <= r_i[i] | (sdn_pkg::RES_BITS'(take[i]) << BIT);
      end
    end
  end

  assign ctrl_o = ctrl_q;
  assign neg_o  = neg_q;
  assign sum_o  = sum_q;
  assign rem_o  = rem_q;
  assign p_o    = p_q;
  assign r_o    = r_q;

endmodule

// ===== sv/safe_direction_normalizer.sv =====
// Pipeline: from input transaction to result through 3 front-end stages,
// 17 bit cells and 1 output register. Throughput: one vector per cycle; the
// whole pipe advances whenever the output register is empty or being taken.
// Reset: asynchronous active low; clears all valid flags and sets
// null_threshold to 66.
`timescale 1ns / 1ps

module safe_direction_normalizer #(
  parameter int unsigned COORD_WIDTH = sdn_pkg::COORD_WIDTH,
  parameter int unsigned IN_W = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [sdn_pkg::THR_W-1:0] cfg_wdata_i,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // tdata fields from bit 0: vec_x, vec_y, vec_z
  input  logic [IN_W-1:0]           s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // tdata fields from bit 0: dir_x, dir_y, dir_z, zero pad
  output logic [55:0]               m_axis_tdata,
  // tuser fields from bit 0: was_null
  output logic                      m_axis_tuser
);

  localparam int unsigned CW  = COORD_WIDTH;
  localparam int unsigned SW  = 2 * CW + 2;
  localparam int unsigned TW  = 2 * CW + 31;
  localparam int unsigned PW  = SW + sdn_pkg::RES_BITS;
  localparam int unsigned NB  = sdn_pkg::RES_BITS;
  localparam int unsigned OW  = sdn_pkg::OUT_W;

  logic [sdn_pkg::THR_W-1:0] thr_q;
  logic                      adv;

  // chain taps: index 0 feeds the cell for bit NB-1, index NB is the last cell out
  sdn_pkg::ctrl_t             ctrl_s [NB+1];
  logic [2:0]                 neg_s  [NB+1];
  logic [SW-1:0]              sum_s  [NB+1];
  logic [2:0][TW-1:0]         rem_s  [NB+1];
  logic [2:0][PW-1:0]         p_s    [NB+1];
  logic [2:0][NB-1:0]         r_s    [NB+1];

  logic [2:0][CW-1:0]         vec;
  logic                       out_v_q;
  logic [2:0][OW-1:0]         dir_q;
  logic                       null_q;
  logic [2:0][OW-1:0]         dir_d;

  // pipe moves as one; output register decouples downstream stalls
  assign adv           = !out_v_q || m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= sdn_pkg::THR_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_unpack
    assign vec[i] = s_axis_tdata[i*CW +: CW];
  end

  sdn_prep #(.CW(CW), .SW(SW), .TW(TW)) u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s_axis_tvalid),
    .thr_i   (thr_q),
    .vec_i   (vec),
    .ctrl_o  (ctrl_s[0]),
    .neg_o   (neg_s[0]),
    .sum_o   (sum_s[0]),
    .tgt_o   (rem_s[0])
  );

  // restoring search starts at r = 0, P = r*S = 0, remainder = target
  assign p_s[0] = '0;
  assign r_s[0] = '0;

  for (genvar k = 0; k < NB; k++) begin : g_cell
    sdn_cell #(.CW(CW), .BIT(NB - 1 - k), .SW(SW), .TW(TW), .PW(PW)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .ctrl_i (ctrl_s[k]),
      .neg_i  (neg_s[k]),
      .sum_i  (sum_s[k]),
      .rem_i  (rem_s[k]),
      .p_i    (p_s[k]),
      .r_i    (r_s[k]),
      .ctrl_o (ctrl_s[k+1]),
      .neg_o  (neg_s[k+1]),
      .sum_o  (sum_s[k+1]),
      .rem_o  (rem_s[k+1]),
      .p_o    (p_s[k+1]),
      .r_o    (r_s[k+1])
    );
  end

  // Near-null vector gives (0,0,1); an all-zero vector that is not null
  // (threshold of zero) has zero length and gives (0,0,0).
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dir_d[i] = neg_s[NB][i] ? (~{1'b0, r_s[NB][i]} + OW'(1)) : {1'b0, r_s[NB][i]};
    end
    if (ctrl_s[NB].is_null) begin
      dir_d[0] = '0;
      dir_d[1] = '0;
      dir_d[2] = {1'b0, sdn_pkg::RES_ONE};
    end else if (ctrl_s[NB].is_zero) begin
      dir_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= ctrl_s[NB].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dir_q  <= dir_d;
      null_q <= ctrl_s[NB].is_null;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {2'b00, dir_q[2], dir_q[1], dir_q[0]};
  assign m_axis_tuser  = null_q;

  // null result always carries the default direction
  a_null_default: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |->
      (dir_q[0] == '0 && dir_q[1] == '0 && dir_q[2] == {1'b0, sdn_pkg::RES_ONE}))
    else $error("null result without default direction");

  // a stalled result is not dropped by the pipe
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(dir_q)))
    else $error("stalled result lost or changed");

  // result components stay within plus or minus one
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      ($signed(dir_q[0]) >= -18'sd65536 && $signed(dir_q[0]) <= 18'sd65536 &&
       $signed(dir_q[1]) >= -18'sd65536 && $signed(dir_q[1]) <= 18'sd65536 &&
       $signed(dir_q[2]) >= -18'sd65536 && $signed(dir_q[2]) <= 18'sd65536))
    else $error("direction component out of range");

endmodule
